// ===== hdl/kbct_pkg.sv =====
package kbct_pkg;

  // Flag characters scanned per item (first character in the lowest byte)
  localparam int unsigned FLAG_CHARS = 8;

  localparam logic [7:0] ChrNul = 8'h00;
  localparam logic [7:0] ChrRead = 8'h52;   // 'R'
  localparam logic [7:0] ChrWrite = 8'h57;  // 'W'

  localparam logic DirRead = 1'b0;
  localparam logic DirWrite = 1'b1;

  typedef enum logic [2:0] {
    OUT_NO_DIR     = 3'd0,
    OUT_ZERO_BYTES = 3'd1,
    OUT_ACCUM      = 3'd2,
    OUT_INSERT     = 3'd3,
    OUT_DROP       = 3'd4
  } outcome_e;

  // Classification made by the front end
  typedef enum logic [1:0] {
    CLS_NO_DIR,
    CLS_ZERO_BYTES,
    CLS_LOOKUP
  } cls_e;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } back_state_e;

  typedef struct packed {
    logic [31:0] process_id;
    logic [31:0] device_id;
    logic [63:0] flag_chars;
    logic [31:0] byte_count;
  } in_item_t;

  typedef struct packed {
    outcome_e    outcome;
    logic        direction;
    logic [63:0] key_total;
    logic [63:0] drops_so_far;
    logic [8:0]  entries_used;
  } out_item_t;

  // Classified item, queued between front and back
  typedef struct packed {
    cls_e        kind;
    logic [31:0] process_id;
    logic [31:0] device_id;
    logic        direction;
    logic [31:0] byte_count;
  } work_t;

  // One table entry as stored in RAM
  typedef struct packed {
    logic [31:0] process_id;
    logic [31:0] device_id;
    logic        direction;
    logic [63:0] bytes;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  // Queue status toward the front end
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== hdl/kbct_ram.sv =====
module kbct_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/kbct_front.sv =====
module kbct_front (
  input  logic                start,
  input  kbct_pkg::in_item_t  item_i,
  input  kbct_pkg::q_status_t q_status_i,
  output logic                busy,
  output logic                push_o,
  output kbct_pkg::work_t     work_o
);

  logic       found;
  logic       stop;
  logic       dir;
  logic [7:0] chr;

  // Scan up to the first NUL; first 'W' or 'R' wins
  always_comb begin
    found = 1'b0;
    stop = 1'b0;
    dir = kbct_pkg::DirRead;
    chr = '0;
    for (int i = 0; i < kbct_pkg::FLAG_CHARS; i++) begin
      chr = item_i.flag_chars[8*i +: 8];
      if (!stop) begin
        if (chr == kbct_pkg::ChrNul) begin
          stop = 1'b1;
        end else if (chr == kbct_pkg::ChrWrite) begin
          found = 1'b1;
          dir = kbct_pkg::DirWrite;
          stop = 1'b1;
        end else if (chr == kbct_pkg::ChrRead) begin
          found = 1'b1;
          dir = kbct_pkg::DirRead;
          stop = 1'b1;
        end
      end
    end
  end

  always_comb begin
    work_o.process_id = item_i.process_id;
    work_o.device_id = item_i.device_id;
    work_o.byte_count = item_i.byte_count;
    work_o.direction = found ? dir : kbct_pkg::DirRead;
    priority if (!found) begin
      work_o.kind = kbct_pkg::CLS_NO_DIR;
    end else if (item_i.byte_count == '0) begin
      work_o.kind = kbct_pkg::CLS_ZERO_BYTES;
    end else begin
      work_o.kind = kbct_pkg::CLS_LOOKUP;
    end
  end

  assign busy = q_status_i.full;
  assign push_o = start && !q_status_i.full;

endmodule

// ===== hdl/kbct_queue.sv =====
module kbct_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  kbct_pkg::work_t     push_data_i,
  input  logic                pop_i,
  output kbct_pkg::work_t     head_o,
  output kbct_pkg::q_status_t status_o
);

  kbct_pkg::work_t slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push;
  logic       do_pop;

  assign do_push = push_i && (cnt_q != 2'd2);
  assign do_pop = pop_i && (cnt_q != 2'd0);

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o = slot_q[rd_ptr_q];
  assign status_o.full = (cnt_q == 2'd2);
  assign status_o.empty = (cnt_q == 2'd0);

endmodule

// ===== hdl/kbct_back.sv =====
module kbct_back #(
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kbct_pkg::work_t     head_i,
  input  kbct_pkg::q_status_t q_status_i,
  output logic                pop_o,
  output logic                result_valid_o,
  output kbct_pkg::out_item_t result_o
);

  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

  kbct_pkg::back_state_e state_q, state_d;
  kbct_pkg::work_t       cur_q, cur_d;
  kbct_pkg::out_item_t   res_q, res_d;
  logic                  res_valid_q, res_valid_d;
  logic [CW-1:0]         raddr_q, raddr_d;
  logic                  pend_q, pend_d;
  logic [AW-1:0]         pidx_q, pidx_d;
  logic [CW-1:0]         count_q, count_d;
  logic [63:0]           drops_q, drops_d;

  logic                        re;
  logic                        we;
  logic [AW-1:0]               waddr;
  kbct_pkg::entry_t            wentry;
  logic [kbct_pkg::EntryW-1:0] rdata;
  kbct_pkg::entry_t            rentry;
  logic                        match;
  logic [CW-1:0]               count_inc;
  logic [CW+8:0]               used_now;
  logic [CW+8:0]               used_inc;

  kbct_ram #(
    .WIDTH(kbct_pkg::EntryW),
    .DEPTH(TABLE_ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wentry),
    .re_i   (re),
    .raddr_i(raddr_q[AW-1:0]),
    .rdata_o(rdata)
  );

  assign rentry = kbct_pkg::entry_t'(rdata);
  assign match = (rentry.process_id == cur_q.process_id) &&
                 (rentry.device_id == cur_q.device_id) &&
                 (rentry.direction == cur_q.direction);
  assign count_inc = count_q + CW'(1);
  assign used_now = {9'd0, count_q};
  assign used_inc = {9'd0, count_inc};

  always_comb begin
    state_d = state_q;
    cur_d = cur_q;
    res_d = res_q;
    res_valid_d = 1'b0;
    raddr_d = raddr_q;
    pend_d = 1'b0;
    pidx_d = pidx_q;
    count_d = count_q;
    drops_d = drops_q;
    pop_o = 1'b0;
    re = 1'b0;
    we = 1'b0;
    waddr = '0;
    wentry = '0;
    unique case (state_q)
      kbct_pkg::ST_IDLE: begin
        if (!q_status_i.empty) begin
          pop_o = 1'b1;
          if (head_i.kind == kbct_pkg::CLS_LOOKUP) begin
            cur_d = head_i;
            raddr_d = '0;
            state_d = kbct_pkg::ST_SCAN;
          end else begin
            res_valid_d = 1'b1;
            res_d.outcome = (head_i.kind == kbct_pkg::CLS_NO_DIR) ?
                            kbct_pkg::OUT_NO_DIR : kbct_pkg::OUT_ZERO_BYTES;
            res_d.direction = head_i.direction;
            res_d.key_total = '0;
            res_d.drops_so_far = drops_q;
            res_d.entries_used = used_now[8:0];
          end
        end
      end
      kbct_pkg::ST_SCAN: begin
        // one read issued per cycle over slots 0 .. count-1
        re = (raddr_q < count_q);
        if (re) begin
          raddr_d = raddr_q + CW'(1);
          pend_d = 1'b1;
          pidx_d = raddr_q[AW-1:0];
        end
        priority if (pend_q && match) begin
          we = 1'b1;
          waddr = pidx_q;
          wentry = rentry;
          wentry.bytes = rentry.bytes + {32'd0, cur_q.byte_count};
          res_valid_d = 1'b1;
          res_d.outcome = kbct_pkg::OUT_ACCUM;
          res_d.direction = cur_q.direction;
          res_d.key_total = wentry.bytes;
          res_d.drops_so_far = drops_q;
          res_d.entries_used = used_now[8:0];
          state_d = kbct_pkg::ST_IDLE;
        end else if (!pend_q && !re) begin
          res_valid_d = 1'b1;
          res_d.direction = cur_q.direction;
          if (count_q != CW'(TABLE_ENTRIES)) begin
            we = 1'b1;
            waddr = count_q[AW-1:0];
            wentry.process_id = cur_q.process_id;
            wentry.device_id = cur_q.device_id;
            wentry.direction = cur_q.direction;
            wentry.bytes = {32'd0, cur_q.byte_count};
            count_d = count_inc;
            res_d.outcome = kbct_pkg::OUT_INSERT;
            res_d.key_total = {32'd0, cur_q.byte_count};
            res_d.drops_so_far = drops_q;
            res_d.entries_used = used_inc[8:0];
          end else begin
            drops_d = drops_q + 64'd1;
            res_d.outcome = kbct_pkg::OUT_DROP;
            res_d.key_total = '0;
            res_d.drops_so_far = drops_d;
            res_d.entries_used = used_now[8:0];
          end
          state_d = kbct_pkg::ST_IDLE;
        end else begin
          state_d = kbct_pkg::ST_SCAN;
        end
      end
      default: begin
        state_d = kbct_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kbct_pkg::ST_IDLE;
      res_valid_q <= 1'b0;
      raddr_q <= '0;
      pend_q <= 1'b0;
      count_q <= '0;
      drops_q <= '0;
    end else begin
      state_q <= state_d;
      res_valid_q <= res_valid_d;
      raddr_q <= raddr_d;
      pend_q <= pend_d;
      count_q <= count_d;
      drops_q <= drops_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    res_q <= res_d;
    pidx_q <= pidx_d;
  end

  assign result_valid_o = res_valid_q;
  assign result_o = res_q;

endmodule

// ===== hdl/keyed_byte_counter_table.sv =====
// Skipped items (no direction, zero bytes) pass through the queue to a registered result;
//   a lookup reads slots from 0 upward until it hits, and a miss reads all valid_count slots.
// Throughput: one skipped item per cycle while the back end is idle; a lookup holds the
//   back end for its whole walk, one table RAM read per slot.
// Reset: table empty (fill count zero), drop counter zero; no clearing pass is needed.
// Results are one-cycle strobes; the receiver cannot stall.
module keyed_byte_counter_table #(
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  kbct_pkg::in_item_t  item_i,
  output logic                result_valid_o,
  output kbct_pkg::out_item_t result_o
);

  // Front end: flag scan and classification, pushes into a two-item queue.
  // Busy only while that queue is full.
  kbct_pkg::work_t     push_work;
  logic                push;
  kbct_pkg::work_t     head;
  kbct_pkg::q_status_t q_status;
  logic                pop;

  kbct_front u_front (
    .start     (start),
    .item_i    (item_i),
    .q_status_i(q_status),
    .busy      (busy),
    .push_o    (push),
    .work_o    (push_work)
  );

  // Decouples classification from the table walk
  kbct_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_work),
    .pop_i      (pop),
    .head_o     (head),
    .status_o   (q_status)
  );

  // Back end: entries live in slots 0 .. valid_count-1, so a lookup walks those slots
  // and a miss inserts at slot valid_count, or counts a drop when the table is full.
  kbct_back #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .q_status_i    (q_status),
    .pop_o         (pop),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int unsigned TABLE_ENTRIES = 256;
  // Slowest legal run is ~1400 items x (full-table scan + sender gap); this is
  // several times that.
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned MAX_PRINTED = 40;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                item_start = 1'b0;
  logic                busy;
  kbct_pkg::in_item_t  event_in = '0;
  logic                result_valid_o;
  kbct_pkg::out_item_t result_o;

  keyed_byte_counter_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (item_start),
    .busy          (busy),
    .item_i        (event_in),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow copy of the counter table. Slots fill from 0 upward and are never
  // freed, so slots 0..slots_used-1 are exactly the valid ones.
  // ---------------------------------------------------------------------------
  logic [31:0] slot_pid   [TABLE_ENTRIES];
  logic [31:0] slot_dev   [TABLE_ENTRIES];
  logic        slot_dir   [TABLE_ENTRIES];
  logic [63:0] slot_bytes [TABLE_ENTRIES];
  int unsigned slots_used = 0;
  logic [63:0] drop_count = '0;

  kbct_pkg::out_item_t pending_results[$];
  int unsigned mismatch_count = 0;
  int unsigned outcome_seen[5] = '{default: 0};
  int unsigned events_sent = 0;
  int unsigned cycle_count = 0;

  // Updates the shadow table with one accepted I/O event and returns the result
  // the block must produce for it.
  function automatic kbct_pkg::out_item_t predict_counter_update(kbct_pkg::in_item_t ev);
    kbct_pkg::out_item_t res;
    logic        has_dir;
    logic        stopped;
    logic        dir;
    logic [7:0]  ch;
    int          hit;

    has_dir = 1'b0;
    stopped = 1'b0;
    dir     = kbct_pkg::DirRead;
    // Scan stops at the first NUL; whichever of W/R shows up first wins.
    for (int k = 0; k < kbct_pkg::FLAG_CHARS; k++) begin
      ch = ev.flag_chars[8*k +: 8];
      if (!stopped && !has_dir) begin
        if (ch == kbct_pkg::ChrNul) begin
          stopped = 1'b1;
        end else if (ch == kbct_pkg::ChrWrite) begin
          has_dir = 1'b1;
          dir     = kbct_pkg::DirWrite;
        end else if (ch == kbct_pkg::ChrRead) begin
          has_dir = 1'b1;
          dir     = kbct_pkg::DirRead;
        end
      end
    end

    res.direction = dir;
    res.key_total = '0;
    if (!has_dir) begin
      res.outcome   = kbct_pkg::OUT_NO_DIR;
      res.direction = kbct_pkg::DirRead;
    end else if (ev.byte_count == '0) begin
      res.outcome = kbct_pkg::OUT_ZERO_BYTES;
    end else begin
      hit = -1;
      for (int s = 0; s < slots_used; s++) begin
        if (hit < 0 && slot_pid[s] == ev.process_id && slot_dev[s] == ev.device_id &&
            slot_dir[s] == dir) begin
          hit = s;
        end
      end
      if (hit >= 0) begin
        slot_bytes[hit] = slot_bytes[hit] + 64'(ev.byte_count);  // wraps mod 2^64
        res.outcome     = kbct_pkg::OUT_ACCUM;
        res.key_total   = slot_bytes[hit];
      end else if (slots_used < TABLE_ENTRIES) begin
        slot_pid[slots_used]   = ev.process_id;
        slot_dev[slots_used]   = ev.device_id;
        slot_dir[slots_used]   = dir;
        slot_bytes[slots_used] = 64'(ev.byte_count);
        slots_used++;
        res.outcome   = kbct_pkg::OUT_INSERT;
        res.key_total = 64'(ev.byte_count);
      end else begin
        drop_count  = drop_count + 64'd1;
        res.outcome = kbct_pkg::OUT_DROP;
      end
    end
    res.drops_so_far = drop_count;
    res.entries_used = 9'(slots_used);
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (mismatch_count < MAX_PRINTED) begin
      $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every strobe must match the oldest outstanding prediction.
  // Sampled at the rising edge, before the block's own updates land.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    kbct_pkg::out_item_t want;
    if (result_valid_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 64'(result_o.outcome), '0);
      end else begin
        want = pending_results.pop_front();
        outcome_seen[int'(want.outcome)]++;
        if (result_o.outcome !== want.outcome)
          report_mismatch("outcome", 64'(result_o.outcome), 64'(want.outcome));
        if (result_o.direction !== want.direction)
          report_mismatch("direction", 64'(result_o.direction), 64'(want.direction));
        if (result_o.key_total !== want.key_total)
          report_mismatch("key_total", result_o.key_total, want.key_total);
        if (result_o.drops_so_far !== want.drops_so_far)
          report_mismatch("drops_so_far", result_o.drops_so_far, want.drops_so_far);
        if (result_o.entries_used !== want.entries_used)
          report_mismatch("entries_used", 64'(result_o.entries_used),
                          64'(want.entries_used));
      end
    end
  end

  // Watchdog: a hung handshake or lost result ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Sends one item: optional idle cycles first, then hold start until the block
  // takes it. start is left high so back-to-back items need no extra toggle.
  task automatic send_event(kbct_pkg::in_item_t ev, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      item_start <= 1'b0;
    end
    @(negedge clk_i);
    item_start <= 1'b1;
    event_in   <= ev;
    do @(posedge clk_i); while (busy);
    pending_results.push_back(predict_counter_update(ev));
    events_sent++;
  endtask

  function automatic kbct_pkg::in_item_t io_event(logic [31:0] pid, logic [31:0] dev,
                                                  logic [63:0] flags, logic [31:0] count);
    kbct_pkg::in_item_t ev;
    ev.process_id = pid;
    ev.device_id  = dev;
    ev.flag_chars = flags;
    ev.byte_count = count;
    return ev;
  endfunction

  // First character goes to the lowest byte; unused bytes stay NUL.
  function automatic logic [63:0] flags_of(string s);
    logic [63:0] f;
    f = '0;
    for (int k = 0; k < s.len() && k < kbct_pkg::FLAG_CHARS; k++) f[8*k +: 8] = s[k];
    return f;
  endfunction

  // Any non-NUL byte that is neither W nor R.
  function automatic logic [7:0] plain_char();
    logic [7:0] ch;
    do ch = 8'($urandom_range(1, 255));
    while (ch == kbct_pkg::ChrWrite || ch == kbct_pkg::ChrRead);
    return ch;
  endfunction

  // Random flag string whose direction char sits at a random position behind
  // plain chars. With nul_first the direction char is hidden behind a NUL.
  function automatic logic [63:0] make_flags(logic is_write, logic nul_first);
    logic [63:0] f;
    int          pos;
    logic [7:0]  dir_ch;
    dir_ch = is_write ? kbct_pkg::ChrWrite : kbct_pkg::ChrRead;
    pos    = $urandom_range(0, kbct_pkg::FLAG_CHARS - 1);
    for (int k = 0; k < kbct_pkg::FLAG_CHARS; k++) begin
      if (k < pos) f[8*k +: 8] = plain_char();
      else if (k == pos) f[8*k +: 8] = nul_first ? kbct_pkg::ChrNul : dir_ch;
      else if (k == pos + 1 && nul_first) f[8*k +: 8] = dir_ch;
      else f[8*k +: 8] = 8'($urandom_range(0, 255));
    end
    return f;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Flag scanning: empty string, W/R first, W vs R ordering, chars hidden
  // behind a NUL, lowercase, no NUL at all, direction in the last slot.
  task automatic test_flag_scan();
    logic [31:0] pid;
    logic [31:0] dev;
    pid = 32'h0000_1234;
    dev = 32'h0080_0010;
    send_event(io_event(pid, dev, 64'h0, 32'd512), 0);
    send_event(io_event(pid, dev, flags_of("WS"), 32'd512), 0);
    send_event(io_event(pid, dev, flags_of("RA"), 32'd4096), 0);
    send_event(io_event(pid, dev, flags_of("FWR"), 32'd8), 0);
    send_event(io_event(pid, dev, flags_of("SRW"), 32'd8), 0);
    // "S", NUL, "W": write char sits past the terminator
    send_event(io_event(pid, dev, 64'h0000_0000_0057_0053, 32'd8), 0);
    send_event(io_event(pid, dev, flags_of("wrfs"), 32'd8), 0);
    send_event(io_event(pid, dev, '1, 32'd8), 0);
    send_event(io_event(pid, dev, flags_of("ABCDEFGW"), 32'd100), 0);
    send_event(io_event(pid, dev, flags_of("ABCDEFGR"), 32'd100), 0);
  endtask

  // Zero-byte skips, extreme ids and counts, read/write keys kept apart.
  task automatic test_key_updates();
    send_event(io_event(32'd7, 32'd1, flags_of("W"), 32'd0), 0);
    send_event(io_event(32'd7, 32'd1, flags_of("R"), 32'd0), 0);
    send_event(io_event(32'd7, 32'd1, flags_of("AS"), 32'd0), 0);  // no dir wins
    send_event(io_event('0, '0, flags_of("W"), '1), 0);
    send_event(io_event('0, '0, flags_of("W"), '1), 0);
    send_event(io_event('1, '1, flags_of("R"), 32'd1), 0);
    send_event(io_event('1, '1, flags_of("W"), '1), 0);
    send_event(io_event('1, '0, flags_of("R"), 32'd1), 0);
    send_event(io_event('0, '1, flags_of("RS"), 32'd3), 0);
    send_event(io_event('0, '0, flags_of("W"), 32'd1), 0);
    send_event(io_event('1, '1, flags_of("R"), '1), 0);
  endtask

  // Mostly well-formed events, about half on keys already in the table so
  // accumulation is common; fresh keys fill the table and then get dropped.
  // A slice is noise: random flags, NUL-hidden directions, zero counts.
  task automatic test_table_traffic(int idle_pct, int n_events);
    kbct_pkg::in_item_t ev;
    int       pick;
    int       slot;
    logic     dir;
    repeat (n_events) begin
      pick          = $urandom_range(99);
      ev.process_id = $urandom;
      ev.device_id  = $urandom;
      dir           = 1'($urandom_range(1));
      if (slots_used > 0 && $urandom_range(99) < 55) begin
        slot          = $urandom_range(slots_used - 1);
        ev.process_id = slot_pid[slot];
        ev.device_id  = slot_dev[slot];
        dir           = ($urandom_range(3) != 0) ? slot_dir[slot] : ~slot_dir[slot];
      end
      ev.byte_count = $urandom;
      if ($urandom_range(19) == 0) ev.byte_count = '1;
      if (ev.byte_count == '0) ev.byte_count = 32'd1;
      if (pick < 6) begin
        ev.flag_chars = {$urandom, $urandom};
        if ($urandom_range(3) == 0) ev.byte_count = '0;
      end else if (pick < 10) begin
        ev.flag_chars = make_flags(dir, 1'b1);
      end else if (pick < 15) begin
        ev.flag_chars = make_flags(dir, 1'b0);
        ev.byte_count = '0;
      end else begin
        ev.flag_chars = make_flags(dir, 1'b0);
      end
      send_event(ev, idle_pct);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_flag_scan();
    test_key_updates();
    // sender mostly busy, then mostly idle, then back to back
    test_table_traffic(11, 450);
    test_table_traffic(87, 450);
    test_table_traffic(0, 450);

    @(negedge clk_i);
    item_start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    // one full table scan of slack to catch stray strobes
    repeat (TABLE_ENTRIES + 8) @(posedge clk_i);

    $display("sent %0d I/O events: %0d no-direction, %0d zero-byte, %0d accumulated,",
             events_sent, outcome_seen[0], outcome_seen[1], outcome_seen[2]);
    $display("  %0d inserted, %0d dropped on full table; %0d keys held, %0d mismatches",
             outcome_seen[3], outcome_seen[4], slots_used, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
